@@ sv/icmp_rc_pkg.sv @@
// Shared types, constants and helpers for the ICMPv4 receive classifier.
// Used by the accumulator, the verdict logic, the configuration registers and the top level.
// Depends on nothing.
package icmp_rc_pkg;

    // ICMP message types and the quoted IP protocol of interest.
    localparam logic [7:0] ICMP_UNREACH       = 8'd3;
    localparam logic [7:0] ICMP_ECHO_REQ      = 8'd8;
    localparam logic [7:0] ICMP_TTL_EXPIRED   = 8'd11;
    localparam logic [7:0] ICMP_PARAM_PROBLEM = 8'd12;
    localparam logic [7:0] IP_PROTO_UDP       = 8'd17;
    localparam logic [3:0] IP_VERSION_4       = 4'd4;

    // Destination-unreachable codes that have an error class of their own.
    // Net, unknown net, prohibited net and net for type of service all count as a net error.
    localparam logic [7:0] UNREACH_NET        = 8'd0;
    localparam logic [7:0] UNREACH_PROTO      = 8'd2;
    localparam logic [7:0] UNREACH_PORT       = 8'd3;
    localparam logic [7:0] UNREACH_FRAG       = 8'd4;
    localparam logic [7:0] UNREACH_NET_UNKN   = 8'd6;
    localparam logic [7:0] UNREACH_NET_PROHIB = 8'd9;
    localparam logic [7:0] UNREACH_NET_TOS    = 8'd11;

    localparam logic [7:0] LOOPBACK_NET       = 8'd127;
    localparam logic [3:0] MULTICAST_NIBBLE   = 4'hE;

    // Length limits in bytes, and the width of length comparisons.
    localparam int MIN_MSG_LEN     = 8;
    localparam int MIN_ERR_MSG_LEN = 28;
    localparam int MIN_QUOTED_HLEN = 20;
    localparam int ICMP_HDR_LEN    = 8;
    localparam int UDP_HDR_LEN     = 8;
    localparam int LEN_CMP_W       = 17;

    localparam logic [11:0] DEFAULT_MAX_LENGTH = 12'd1500;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ADDRESS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SUBNET_MASK = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IFACE_KNOWN = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH  = 3'd3;

    typedef enum logic [2:0] {
        V_MALFORMED    = 3'd0,
        V_BAD_CHECKSUM = 3'd1,
        V_IGNORED      = 3'd2,
        V_BAD_DEST     = 3'd3,
        V_BAD_SOURCE   = 3'd4,
        V_ECHO_REPLY   = 3'd5,
        V_ERR_REPORT   = 3'd6,
        V_ERR_UNUSABLE = 3'd7
    } verdict_t;

    typedef enum logic [2:0] {
        EC_NET        = 3'd0,
        EC_PROTOCOL   = 3'd1,
        EC_PORT       = 3'd2,
        EC_TOO_BIG    = 3'd3,
        EC_HOST       = 3'd4,
        EC_PROTO_ERR  = 3'd5
    } err_class_t;

    typedef struct packed {
        logic [31:0] own_address;
        logic [31:0] subnet_mask;
        logic        iface_known;
        logic [11:0] max_length;
    } cfg_t;

    // Per-message capture state, apart from the byte count.
    typedef struct packed {
        logic        oversize;
        logic [15:0] full_sum;
        logic [15:0] body_sum;
        logic [7:0]  held_high_byte;
        logic [7:0]  msg_type;
        logic [7:0]  msg_code;
        logic [7:0]  quoted_ver_ihl;
        logic [7:0]  quoted_protocol;
        logic [31:0] quoted_source;
        logic [31:0] quoted_dest;
        logic [31:0] quoted_ports;
    } msg_fields_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [15:0] reply_checksum;
        logic [31:0] reply_target;
        logic [2:0]  error_class;
        logic [31:0] local_addr;
        logic [15:0] local_port;
        logic [31:0] remote_addr;
        logic [15:0] remote_port;
    } result_t;

    // One's-complement add with end-around carry.
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] w);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, w};
        return s[15:0] + {15'b0, s[16]};
    endfunction

endpackage

@@ sv/icmp_rc_if.sv @@
// Valid/ready channel interfaces for the message byte stream and the verdict stream.
// Depends on nothing.
interface icmp_rc_msg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  msg_byte;
    logic        last_byte;
    logic [31:0] src_address;
    logic [31:0] dst_address;

    modport source (output valid, msg_byte, last_byte, src_address, dst_address,
                    input ready);
    modport sink   (input valid, msg_byte, last_byte, src_address, dst_address,
                    output ready);
endinterface

interface icmp_rc_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  verdict;
    logic [15:0] reply_checksum;
    logic [31:0] reply_target;
    logic [2:0]  error_class;
    logic [31:0] local_addr;
    logic [15:0] local_port;
    logic [31:0] remote_addr;
    logic [15:0] remote_port;

    modport source (output valid, verdict, reply_checksum, reply_target, error_class,
                    local_addr, local_port, remote_addr, remote_port,
                    input ready);
    modport sink   (input valid, verdict, reply_checksum, reply_target, error_class,
                    local_addr, local_port, remote_addr, remote_port,
                    output ready);
endinterface

@@ sv/icmp_rc_accum.sv @@
// Per-message accumulator: byte count, running checksums and captured header fields.
// Depends on icmp_rc_pkg.
module icmp_rc_accum
    import icmp_rc_pkg::*;
#(
    parameter int MAX_MSG_BYTES = 2048,
    localparam int POS_W = $clog2(MAX_MSG_BYTES + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       msg_byte,
    input  logic             last_byte,
    output logic [POS_W-1:0] pos_next,
    output msg_fields_t      fld_next
);

    logic [POS_W-1:0]     pos_reg;
    msg_fields_t          fld_reg;
    logic [15:0]          word;
    logic [5:0]           qhl;
    logic [LEN_CMP_W-1:0] pos_ext;
    logic [LEN_CMP_W-1:0] ports_lo;

    always_comb
    begin
        pos_next = pos_reg;
        fld_next = fld_reg;
        word     = {fld_reg.held_high_byte, msg_byte};
        qhl      = {fld_reg.quoted_ver_ihl[3:0], 2'b00};
        pos_ext  = LEN_CMP_W'(pos_reg);
        ports_lo = LEN_CMP_W'(qhl) + LEN_CMP_W'(ICMP_HDR_LEN);

        if (pos_reg >= POS_W'(MAX_MSG_BYTES))
        begin
            // Bytes past the limit are neither counted nor summed.
            fld_next.oversize = 1'b1;
        end
        else
        begin
            if (!pos_reg[0])
            begin
                fld_next.held_high_byte = msg_byte;
                // An odd final byte is padded with a zero low byte.
                if (last_byte)
                begin
                    fld_next.full_sum = oc_add(fld_reg.full_sum, {msg_byte, 8'h00});
                    if (pos_reg >= POS_W'(4))
                    begin
                        fld_next.body_sum = oc_add(fld_reg.body_sum, {msg_byte, 8'h00});
                    end
                end
            end
            else
            begin
                fld_next.full_sum = oc_add(fld_reg.full_sum, word);
                if (pos_reg >= POS_W'(5))
                begin
                    fld_next.body_sum = oc_add(fld_reg.body_sum, word);
                end
            end

            if (pos_reg == POS_W'(0))
                fld_next.msg_type = msg_byte;
            if (pos_reg == POS_W'(1))
                fld_next.msg_code = msg_byte;
            if (pos_reg == POS_W'(8))
                fld_next.quoted_ver_ihl = msg_byte;
            if (pos_reg == POS_W'(17))
                fld_next.quoted_protocol = msg_byte;
            if (pos_reg >= POS_W'(20) && pos_reg <= POS_W'(23))
                fld_next.quoted_source = {fld_reg.quoted_source[23:0], msg_byte};
            if (pos_reg >= POS_W'(24) && pos_reg <= POS_W'(27))
                fld_next.quoted_dest = {fld_reg.quoted_dest[23:0], msg_byte};
            // The UDP ports follow the quoted IP header, whose length is known by now.
            if (pos_reg > POS_W'(8) && pos_ext >= ports_lo
                && pos_ext < ports_lo + LEN_CMP_W'(4))
                fld_next.quoted_ports = {fld_reg.quoted_ports[23:0], msg_byte};

            pos_next = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            fld_reg <= '0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                pos_reg <= '0;
                fld_reg <= '0;
            end
            else
            begin
                pos_reg <= pos_next;
                fld_reg <= fld_next;
            end
        end
    end

endmodule

@@ sv/icmp_rc_verdict.sv @@
// Verdict logic: classifies a completed message from its captured fields.
// Depends on icmp_rc_pkg.
module icmp_rc_verdict
    import icmp_rc_pkg::*;
#(
    parameter int MAX_MSG_BYTES = 2048,
    localparam int POS_W = $clog2(MAX_MSG_BYTES + 1)
)
(
    input  logic [POS_W-1:0] msg_len,
    input  msg_fields_t      fld,
    input  logic [31:0]      src_address,
    input  logic [31:0]      dst_address,
    input  cfg_t             cfg,
    output result_t          res
);

    logic [LEN_CMP_W-1:0] len;
    logic [5:0]           qhl;
    logic [31:0]          subnet_bcast;
    logic                 err_type;
    err_class_t           unreach_class;

    always_comb
    begin
        case (fld.msg_code)
            UNREACH_NET, UNREACH_NET_UNKN, UNREACH_NET_PROHIB, UNREACH_NET_TOS:
                unreach_class = EC_NET;
            UNREACH_PROTO: unreach_class = EC_PROTOCOL;
            UNREACH_PORT:  unreach_class = EC_PORT;
            UNREACH_FRAG:  unreach_class = EC_TOO_BIG;
            default:       unreach_class = EC_HOST;
        endcase
    end

    always_comb
    begin
        len          = LEN_CMP_W'(msg_len);
        qhl          = {fld.quoted_ver_ihl[3:0], 2'b00};
        subnet_bcast = (cfg.own_address & cfg.subnet_mask) | ~cfg.subnet_mask;
        err_type     = fld.msg_type inside {ICMP_UNREACH, ICMP_TTL_EXPIRED,
                                            ICMP_PARAM_PROBLEM};
        res          = '0;

        if (fld.oversize || len < LEN_CMP_W'(MIN_MSG_LEN))
        begin
            res.verdict = V_MALFORMED;
        end
        else if (fld.full_sum != 16'hFFFF)
        begin
            res.verdict = V_BAD_CHECKSUM;
        end
        else if (err_type)
        begin
            if (len < LEN_CMP_W'(MIN_ERR_MSG_LEN)
                || fld.quoted_ver_ihl[7:4] != IP_VERSION_4
                || qhl < 6'(MIN_QUOTED_HLEN)
                || LEN_CMP_W'(qhl) + LEN_CMP_W'(ICMP_HDR_LEN + UDP_HDR_LEN) > len
                || fld.quoted_protocol != IP_PROTO_UDP)
            begin
                res.verdict = V_ERR_UNUSABLE;
            end
            else
            begin
                res.verdict = V_ERR_REPORT;
                if (fld.msg_type == ICMP_UNREACH)
                    res.error_class = unreach_class;
                else if (fld.msg_type == ICMP_TTL_EXPIRED)
                    res.error_class = EC_HOST;
                else
                    res.error_class = EC_PROTO_ERR;
                res.local_addr  = fld.quoted_source;
                res.remote_addr = fld.quoted_dest;
                res.local_port  = fld.quoted_ports[31:16];
                res.remote_port = fld.quoted_ports[15:0];
            end
        end
        else if (fld.msg_type != ICMP_ECHO_REQ)
        begin
            res.verdict = V_IGNORED;
        end
        else if (cfg.iface_known && (dst_address == '1 || dst_address == subnet_bcast))
        begin
            res.verdict = V_BAD_DEST;
        end
        else if (src_address == '0 || src_address[31:24] == LOOPBACK_NET
                 || src_address[31:28] == MULTICAST_NIBBLE || src_address == '1)
        begin
            res.verdict = V_BAD_SOURCE;
        end
        else if (len > LEN_CMP_W'(cfg.max_length))
        begin
            res.verdict = V_MALFORMED;
        end
        else
        begin
            // Zeroing type and code leaves only the words from byte 4 on.
            res.verdict        = V_ECHO_REPLY;
            res.reply_checksum = ~fld.body_sum;
            res.reply_target   = src_address;
        end
    end

endmodule

@@ sv/icmp_rc_top_note.sv @@
// Configuration register file for the ICMPv4 receive classifier.
// Depends on icmp_rc_pkg.
module icmp_rc_cfg
    import icmp_rc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_OWN_ADDRESS: cfg_next.own_address = cfg_data;
                CFG_SUBNET_MASK: cfg_next.subnet_mask = cfg_data;
                CFG_IFACE_KNOWN: cfg_next.iface_known = cfg_data[0];
                CFG_MAX_LENGTH:  cfg_next.max_length  = cfg_data[11:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_address <= '0;
            cfg_reg.subnet_mask <= '0;
            cfg_reg.iface_known <= 1'b1;
            cfg_reg.max_length  <= DEFAULT_MAX_LENGTH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/icmpv4_receive_classifier.sv @@
// ICMPv4 receive classifier. Message bytes enter on the msg channel one per transaction,
// with the IP addresses of the carrying datagram; one verdict transaction leaves on the
// result channel for each byte marked last. A byte is taken every cycle while results are
// drained: an input register and a result register bracket a single pass of update and
// classify logic. Write configuration registers only while no message is in flight.
module icmpv4_receive_classifier
    import icmp_rc_pkg::*;
#(
    parameter int MAX_MSG_BYTES = 2048
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    icmp_rc_msg_if.sink            msg,
    icmp_rc_result_if.source       result,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    localparam int POS_W = $clog2(MAX_MSG_BYTES + 1);

    cfg_t        cfg;
    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [31:0] src_reg;
    logic [31:0] dst_reg;
    logic        advance;
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     res_reg;
    result_t     res_next;
    logic [POS_W-1:0] pos_next;
    msg_fields_t fld_next;

    icmp_rc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // A byte that yields no verdict never waits on the result side.
    assign advance   = in_valid_reg && (!last_reg || !out_valid_reg || result.ready);
    assign msg.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (msg.ready)
        begin
            in_valid_reg <= msg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (msg.ready && msg.valid)
        begin
            byte_reg <= msg.msg_byte;
            last_reg <= msg.last_byte;
            src_reg  <= msg.src_address;
            dst_reg  <= msg.dst_address;
        end
    end

    icmp_rc_accum #(.MAX_MSG_BYTES(MAX_MSG_BYTES)) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .msg_byte  (byte_reg),
        .last_byte (last_reg),
        .pos_next  (pos_next),
        .fld_next  (fld_next)
    );

    icmp_rc_verdict #(.MAX_MSG_BYTES(MAX_MSG_BYTES)) u_verdict (
        .msg_len     (pos_next),
        .fld         (fld_next),
        .src_address (src_reg),
        .dst_address (dst_reg),
        .cfg         (cfg),
        .res         (res_next)
    );

    always_comb
    begin
        if (advance && last_reg)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.verdict        = res_reg.verdict;
    assign result.reply_checksum = res_reg.reply_checksum;
    assign result.reply_target   = res_reg.reply_target;
    assign result.error_class    = res_reg.error_class;
    assign result.local_addr     = res_reg.local_addr;
    assign result.local_port     = res_reg.local_port;
    assign result.remote_addr    = res_reg.remote_addr;
    assign result.remote_port    = res_reg.remote_port;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the ICMPv4 receive classifier. It sends whole ICMP messages
// byte by byte on the msg channel, predicts each verdict and compares every result field.
// Depends on icmp_rc_pkg, the channel interfaces and icmpv4_receive_classifier.
module tb;
    import icmp_rc_pkg::*;

    localparam int MSG_LIMIT = 2048;
    localparam int PIPE_DRAIN = 4;
    localparam int RANDOM_BYTES = 240;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [31:0] GOOD_SRC = 32'h0A00_0001;
    localparam logic [31:0] GOOD_DST = 32'h0A00_0002;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_UNUSED = CFG_MAX_LENGTH + 1'b1;
    localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;
    localparam logic [7:0] ICMP_TYPE_MAX = 8'hFF;
    localparam logic [7:0] UNREACH_HOST = 8'd1;
    localparam logic [7:0] IP_PROTO_TCP = 8'd6;
    localparam logic [7:0] QUOTE_IHL5 = {IP_VERSION_4, 4'd5};

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    icmp_rc_msg_if msg ();
    icmp_rc_result_if result ();

    icmpv4_receive_classifier #(.MAX_MSG_BYTES(MSG_LIMIT)) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .msg(msg),
        .result(result),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Shadow of the configuration registers.
    logic [31:0] sh_own;
    logic [31:0] sh_mask;
    logic        sh_known;
    logic [11:0] sh_maxlen;

    // Per-message capture state of the predictor.
    int          rx_count;
    logic        rx_oversize;
    logic [15:0] sum_all;
    logic [15:0] sum_body;
    logic [7:0]  hi_byte;
    logic [7:0]  m_type;
    logic [7:0]  m_code;
    logic [7:0]  q_verihl;
    logic [7:0]  q_proto;
    logic [31:0] q_src;
    logic [31:0] q_dst;
    logic [31:0] q_ports;

    result_t     pending_verdicts[$];
    logic [7:0]  frame[$];

    bit tx_idle_on;
    bit rx_idle_on;
    int rx_hold;
    int errors;
    int sent_bytes;
    int sent_msgs;
    int n_results;
    int verdict_seen[8];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [15:0] ones_sum(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[15:0] + {15'b0, t[16]};
    endfunction

    function automatic void clear_msg_state();
        rx_count = 0;
        rx_oversize = 1'b0;
        sum_all = '0;
        sum_body = '0;
        hi_byte = '0;
        m_type = '0;
        m_code = '0;
        q_verihl = '0;
        q_proto = '0;
        q_src = '0;
        q_dst = '0;
        q_ports = '0;
    endfunction

    // Advances the message state by one byte; returns 1 with the verdict on the last byte.
    function automatic bit classify_byte(input logic [7:0] b, input logic last,
                                         input logic [31:0] src, input logic [31:0] dst,
                                         output result_t res);
        int len;
        int qhl;
        res = '0;
        if (rx_count >= MSG_LIMIT)
            rx_oversize = 1'b1;
        else
        begin
            if (rx_count % 2 == 0)
            begin
                hi_byte = b;
                // An odd final byte is padded with a zero low byte.
                if (last)
                begin
                    sum_all = ones_sum(sum_all, {b, 8'h00});
                    if (rx_count >= 4)
                        sum_body = ones_sum(sum_body, {b, 8'h00});
                end
            end
            else
            begin
                sum_all = ones_sum(sum_all, {hi_byte, b});
                if (rx_count >= 5)
                    sum_body = ones_sum(sum_body, {hi_byte, b});
            end
            if (rx_count == 0)
                m_type = b;
            if (rx_count == 1)
                m_code = b;
            if (rx_count == 8)
                q_verihl = b;
            if (rx_count == 17)
                q_proto = b;
            if (rx_count >= 20 && rx_count <= 23)
                q_src = {q_src[23:0], b};
            if (rx_count >= 24 && rx_count <= 27)
                q_dst = {q_dst[23:0], b};
            qhl = q_verihl[3:0] * 4;
            if (rx_count > 8 && rx_count >= 8 + qhl && rx_count < 12 + qhl)
                q_ports = {q_ports[23:0], b};
            rx_count++;
        end
        if (!last)
            return 1'b0;

        len = rx_count;
        qhl = q_verihl[3:0] * 4;
        if (rx_oversize || len < MIN_MSG_LEN)
            res.verdict = V_MALFORMED;
        else if (sum_all != 16'hFFFF)
            res.verdict = V_BAD_CHECKSUM;
        else if (m_type == ICMP_UNREACH || m_type == ICMP_TTL_EXPIRED ||
                 m_type == ICMP_PARAM_PROBLEM)
        begin
            if (len < MIN_ERR_MSG_LEN || q_verihl[7:4] != IP_VERSION_4 ||
                qhl < MIN_QUOTED_HLEN || ICMP_HDR_LEN + qhl + UDP_HDR_LEN > len ||
                q_proto != IP_PROTO_UDP)
                res.verdict = V_ERR_UNUSABLE;
            else
            begin
                res.verdict = V_ERR_REPORT;
                if (m_type == ICMP_UNREACH)
                begin
                    case (m_code)
                        UNREACH_NET, UNREACH_NET_UNKN, UNREACH_NET_PROHIB, UNREACH_NET_TOS:
                            res.error_class = EC_NET;
                        UNREACH_PROTO: res.error_class = EC_PROTOCOL;
                        UNREACH_PORT:  res.error_class = EC_PORT;
                        UNREACH_FRAG:  res.error_class = EC_TOO_BIG;
                        default:       res.error_class = EC_HOST;
                    endcase
                end
                else if (m_type == ICMP_TTL_EXPIRED)
                    res.error_class = EC_HOST;
                else
                    res.error_class = EC_PROTO_ERR;
                res.local_addr = q_src;
                res.remote_addr = q_dst;
                res.local_port = q_ports[31:16];
                res.remote_port = q_ports[15:0];
            end
        end
        else if (m_type != ICMP_ECHO_REQ)
            res.verdict = V_IGNORED;
        else if (sh_known && (dst == ALL_ONES || dst == ((sh_own & sh_mask) | ~sh_mask)))
            res.verdict = V_BAD_DEST;
        else if (src == '0 || src[31:24] == LOOPBACK_NET || src[31:28] == MULTICAST_NIBBLE ||
                 src == ALL_ONES)
            res.verdict = V_BAD_SOURCE;
        else if (len > sh_maxlen)
            res.verdict = V_MALFORMED;
        else
        begin
            res.verdict = V_ECHO_REPLY;
            res.reply_checksum = ~sum_body;
            res.reply_target = src;
        end
        clear_msg_state();
        return 1'b1;
    endfunction

    function automatic void match_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    task automatic check_result();
        result_t want;
        if (pending_verdicts.size() == 0)
        begin
            $error("verdict: expected none, actual %0d", result.verdict);
            errors++;
            return;
        end
        want = pending_verdicts.pop_front();
        match_field("verdict", want.verdict, result.verdict);
        match_field("reply_checksum", want.reply_checksum, result.reply_checksum);
        match_field("reply_target", want.reply_target, result.reply_target);
        match_field("error_class", want.error_class, result.error_class);
        match_field("local_addr", want.local_addr, result.local_addr);
        match_field("local_port", want.local_port, result.local_port);
        match_field("remote_addr", want.remote_addr, result.remote_addr);
        match_field("remote_port", want.remote_port, result.remote_port);
        n_results++;
        verdict_seen[want.verdict]++;
    endtask

    // Result side: random stalls per transaction, plus a long hold when a test asks for one.
    initial
    begin
        int stall;
        result.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold > 0)
            begin
                repeat (rx_hold)
                begin
                    @(negedge clk);
                    result.ready <= 1'b0;
                end
                rx_hold = 0;
            end
            stall = rx_idle_on ? $urandom_range(0, 10) : 0;
            repeat (stall)
            begin
                @(negedge clk);
                result.ready <= 1'b0;
            end
            @(negedge clk);
            result.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result.valid);
            check_result();
        end
    end

    // Valid stays high after a transaction so that back-to-back bytes need no bubble.
    task automatic send_byte(input logic [7:0] b, input logic last,
                             input logic [31:0] src, input logic [31:0] dst);
        int gap;
        result_t res;
        gap = tx_idle_on ? $urandom_range(0, 10) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            msg.valid <= 1'b0;
        end
        @(negedge clk);
        msg.valid <= 1'b1;
        msg.msg_byte <= b;
        msg.last_byte <= last;
        msg.src_address <= src;
        msg.dst_address <= dst;
        do
            @(posedge clk);
        while (!msg.ready);
        if (classify_byte(b, last, src, dst, res))
            pending_verdicts.push_back(res);
        sent_bytes++;
    endtask

    task automatic send_frame(input logic [31:0] src, input logic [31:0] dst);
        for (int i = 0; i < frame.size(); i++)
            send_byte(frame[i], i == frame.size() - 1, src, dst);
        sent_msgs++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        msg.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_OWN_ADDRESS: sh_own = value;
            CFG_SUBNET_MASK: sh_mask = value;
            CFG_IFACE_KNOWN: sh_known = value[0];
            CFG_MAX_LENGTH:  sh_maxlen = value[11:0];
            default: ;
        endcase
    endtask

    // Unused upper bits of the narrow registers carry random junk.
    task automatic set_config(input logic [31:0] own, input logic [31:0] mask,
                              input logic known, input logic [11:0] maxlen);
        write_reg(CFG_OWN_ADDRESS, own);
        write_reg(CFG_SUBNET_MASK, mask);
        write_reg(CFG_IFACE_KNOWN, {31'($urandom), known});
        write_reg(CFG_MAX_LENGTH, {20'($urandom), maxlen});
    endtask

    // Fills in the checksum so that the message sums to all ones.
    function automatic void seal_frame();
        logic [15:0] s;
        logic [15:0] cs;
        if (frame.size() < 4)
            return;
        frame[2] = '0;
        frame[3] = '0;
        s = '0;
        for (int i = 0; i < frame.size(); i += 2)
            s = ones_sum(s, {frame[i], (i + 1 < frame.size()) ? frame[i + 1] : 8'h00});
        cs = ~s;
        frame[2] = cs[15:8];
        frame[3] = cs[7:0];
    endfunction

    function automatic void build_echo(input int len);
        frame.delete();
        frame.push_back(ICMP_ECHO_REQ);
        for (int i = 1; i < len; i++)
            frame.push_back(8'($urandom));
        seal_frame();
    endfunction

    function automatic void build_error(input logic [7:0] typ, input logic [7:0] code,
                                        input logic [7:0] ver_ihl, input logic [7:0] proto,
                                        input int len);
        frame.delete();
        for (int i = 0; i < len; i++)
            frame.push_back(8'($urandom));
        frame[0] = typ;
        if (len > 1)
            frame[1] = code;
        if (len > 8)
            frame[8] = ver_ihl;
        if (len > 17)
            frame[17] = proto;
        seal_frame();
    endfunction

    function automatic int quote_len(input int ihl, input int extra);
        return ICMP_HDR_LEN + ihl * 4 + UDP_HDR_LEN + extra;
    endfunction

    function automatic logic [31:0] pick_src();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return {LOOPBACK_NET, 24'($urandom)};
            2: return {MULTICAST_NIBBLE, 28'($urandom)};
            3: return ALL_ONES;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_dst();
        case ($urandom_range(0, 19))
            0: return ALL_ONES;
            1: return (sh_own & sh_mask) | ~sh_mask;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_message();
        int kind;
        int ihl;
        int full;
        logic [7:0] typ;
        logic [7:0] code;
        kind = $urandom_range(0, 99);
        case ($urandom_range(0, 2))
            0: typ = ICMP_UNREACH;
            1: typ = ICMP_TTL_EXPIRED;
            default: typ = ICMP_PARAM_PROBLEM;
        endcase
        code = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
        ihl = ($urandom_range(0, 9) < 7) ? 5 : $urandom_range(5, 15);
        full = quote_len(ihl, $urandom_range(0, 12));
        if (kind < 40)
            build_echo($urandom_range(MIN_MSG_LEN, 72));
        else if (kind < 70)
            build_error(typ, code, {IP_VERSION_4, 4'(ihl)}, IP_PROTO_UDP, full);
        else if (kind < 80)
        begin
            // Quote broken in one respect: header byte, protocol or length.
            case ($urandom_range(0, 2))
                0: build_error(typ, code, 8'($urandom), IP_PROTO_UDP, full);
                1: build_error(typ, code, {IP_VERSION_4, 4'(ihl)}, 8'($urandom), full);
                default: build_error(typ, code, {IP_VERSION_4, 4'(ihl)}, IP_PROTO_UDP,
                                     $urandom_range(MIN_MSG_LEN, full - 1));
            endcase
        end
        else if (kind < 88)
        begin
            if ($urandom_range(0, 1) == 0)
                build_echo($urandom_range(MIN_MSG_LEN, 40));
            else
                build_error(typ, code, QUOTE_IHL5, IP_PROTO_UDP, quote_len(5, 0));
            frame[$urandom_range(0, frame.size() - 1)] ^= 8'($urandom_range(1, 255));
        end
        else if (kind < 94)
        begin
            build_echo($urandom_range(MIN_MSG_LEN, 40));
            frame[0] = 8'($urandom);
            seal_frame();
        end
        else
        begin
            frame.delete();
            repeat ($urandom_range(1, 40))
                frame.push_back(8'($urandom));
        end
        send_frame(pick_src(), pick_dst());
    endtask

    task automatic run_random_phase(input int byte_budget);
        int stop_at;
        stop_at = sent_bytes + byte_budget;
        while (sent_bytes < stop_at)
            send_random_message();
        wait_idle();
    endtask

    task automatic test_reset_defaults();
        build_echo(MIN_MSG_LEN);
        send_frame(GOOD_SRC, GOOD_DST);
        // Odd length: the last byte is summed with a zero low byte.
        build_echo(MIN_MSG_LEN + 1);
        send_frame(GOOD_SRC, GOOD_DST);
        build_echo(16);
        for (int i = 4; i < 16; i++)
            frame[i] = (i % 2 == 0) ? 8'h00 : 8'hFF;
        seal_frame();
        send_frame(32'h7FFF_FFFF, GOOD_DST);
        build_echo(12);
        send_frame(GOOD_SRC, ALL_ONES);
        wait_idle();
    endtask

    task automatic test_length_limits();
        build_echo(1);
        send_frame(GOOD_SRC, GOOD_DST);
        build_echo(MIN_MSG_LEN - 1);
        send_frame(GOOD_SRC, GOOD_DST);
        build_echo(16);
        frame[5] ^= 8'h5A;
        send_frame(GOOD_SRC, GOOD_DST);
        build_echo(MIN_MSG_LEN);
        frame[0] = ICMP_ECHO_REPLY;
        seal_frame();
        send_frame(GOOD_SRC, GOOD_DST);
        build_echo(MIN_MSG_LEN);
        frame[0] = ICMP_TYPE_MAX;
        seal_frame();
        send_frame(GOOD_SRC, GOOD_DST);
        wait_idle();

        set_config(32'h0, 32'h0, 1'b1, 12'd8);
        build_echo(MIN_MSG_LEN);
        send_frame(GOOD_SRC, GOOD_DST);
        build_echo(MIN_MSG_LEN + 1);
        send_frame(GOOD_SRC, GOOD_DST);
        wait_idle();
    endtask

    task automatic test_echo_addresses();
        set_config(32'hC0A8_0114, 32'hFFFF_FF00, 1'b1, DEFAULT_MAX_LENGTH);
        build_echo(20);
        send_frame(GOOD_SRC, 32'hC0A8_01FF);
        build_echo(20);
        send_frame(GOOD_SRC, ALL_ONES);
        build_echo(20);
        send_frame(32'h0, GOOD_DST);
        build_echo(20);
        send_frame(32'h7F00_0001, GOOD_DST);
        build_echo(20);
        send_frame(32'hE000_0001, GOOD_DST);
        build_echo(20);
        send_frame(32'hEFFF_FFFF, GOOD_DST);
        build_echo(20);
        send_frame(ALL_ONES, GOOD_DST);
        build_echo(20);
        send_frame(32'hF000_0001, GOOD_DST);
        wait_idle();
        // With the interface unknown, broadcast destinations get an answer.
        set_config(32'hC0A8_0114, 32'hFFFF_FF00, 1'b0, DEFAULT_MAX_LENGTH);
        build_echo(20);
        send_frame(GOOD_SRC, 32'hC0A8_01FF);
        build_echo(20);
        send_frame(GOOD_SRC, ALL_ONES);
        wait_idle();
    endtask

    task automatic test_error_reports();
        logic [7:0] codes[8];
        codes = '{UNREACH_NET, UNREACH_NET_UNKN, UNREACH_NET_PROHIB, UNREACH_NET_TOS,
                  UNREACH_PROTO, UNREACH_PORT, UNREACH_FRAG, UNREACH_HOST};
        foreach (codes[i])
        begin
            build_error(ICMP_UNREACH, codes[i], QUOTE_IHL5, IP_PROTO_UDP, quote_len(5, 0));
            send_frame(GOOD_SRC, GOOD_DST);
        end
        build_error(ICMP_TTL_EXPIRED, 8'h00, QUOTE_IHL5, IP_PROTO_UDP, quote_len(5, 4));
        send_frame(GOOD_SRC, GOOD_DST);
        build_error(ICMP_PARAM_PROBLEM, 8'h00, QUOTE_IHL5, IP_PROTO_UDP, quote_len(5, 0));
        send_frame(GOOD_SRC, GOOD_DST);
        // Quoted header with options moves the UDP ports.
        build_error(ICMP_UNREACH, UNREACH_PORT, {IP_VERSION_4, 4'd15}, IP_PROTO_UDP,
                    quote_len(15, 0));
        send_frame(GOOD_SRC, GOOD_DST);
        // Quotes that cannot be used.
        build_error(ICMP_UNREACH, UNREACH_PORT, QUOTE_IHL5, IP_PROTO_UDP, MIN_ERR_MSG_LEN - 1);
        send_frame(GOOD_SRC, GOOD_DST);
        build_error(ICMP_UNREACH, UNREACH_PORT, {4'd6, 4'd5}, IP_PROTO_UDP, quote_len(5, 0));
        send_frame(GOOD_SRC, GOOD_DST);
        build_error(ICMP_UNREACH, UNREACH_PORT, {IP_VERSION_4, 4'd4}, IP_PROTO_UDP,
                    quote_len(5, 0));
        send_frame(GOOD_SRC, GOOD_DST);
        build_error(ICMP_UNREACH, UNREACH_PORT, {IP_VERSION_4, 4'd15}, IP_PROTO_UDP,
                    quote_len(15, 0) - 1);
        send_frame(GOOD_SRC, GOOD_DST);
        build_error(ICMP_TTL_EXPIRED, 8'h00, QUOTE_IHL5, IP_PROTO_TCP, quote_len(5, 0));
        send_frame(GOOD_SRC, GOOD_DST);
        wait_idle();
    endtask

    task automatic test_unused_register_index();
        set_config(32'h0A01_0203, 32'hFFFF_0000, 1'b1, 12'd40);
        for (int i = CFG_FIRST_UNUSED; i < 2 ** CFG_INDEX_W; i++)
            write_reg(CFG_INDEX_W'(i), $urandom);
        build_echo(40);
        send_frame(GOOD_SRC, 32'h0A01_FFFF);
        build_echo(41);
        send_frame(GOOD_SRC, GOOD_DST);
        build_echo(40);
        send_frame(GOOD_SRC, GOOD_DST);
        wait_idle();
    endtask

    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        rx_hold = 400;
        repeat (30)
        begin
            build_echo(MIN_MSG_LEN);
            send_frame(GOOD_SRC, GOOD_DST);
        end
        wait_idle();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int share;
        share = RANDOM_BYTES / 4;
        set_config(32'hC0A8_0A05, 32'hFFFF_FF00, 1'b1, 12'($urandom_range(20, 80)));
        run_random_phase(share);
        tx_idle_on = 1'b0;
        set_config($urandom, ALL_ONES << $urandom_range(0, 32), 1'b0, 12'd2048);
        run_random_phase(share);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b0;
        set_config(ALL_ONES, ALL_ONES, 1'b1, 12'd8);
        run_random_phase(share);
        rx_idle_on = 1'b1;
        set_config(32'h0, 32'h0, 1'b1, 12'($urandom_range(20, 2048)));
        run_random_phase(share);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        msg.valid = 1'b0;
        msg.msg_byte = '0;
        msg.last_byte = 1'b0;
        msg.src_address = '0;
        msg.dst_address = '0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        rx_hold = 0;
        errors = 0;
        sent_bytes = 0;
        sent_msgs = 0;
        n_results = 0;
        sh_own = '0;
        sh_mask = '0;
        sh_known = 1'b1;
        sh_maxlen = DEFAULT_MAX_LENGTH;
        clear_msg_state();
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_length_limits();
        test_echo_addresses();
        test_error_reports();
        test_unused_register_index();
        test_backpressure();
        test_random_traffic();
        wait_idle();

        $display("Sent %0d messages in %0d bytes; %0d verdicts checked, %0d mismatches.",
                 sent_msgs, sent_bytes, n_results, errors);
        $display("Verdicts by code, malformed up to unusable: %0d %0d %0d %0d %0d %0d %0d %0d",
                 verdict_seen[0], verdict_seen[1], verdict_seen[2], verdict_seen[3],
                 verdict_seen[4], verdict_seen[5], verdict_seen[6], verdict_seen[7]);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // The slowest correct run takes well under half a millisecond.
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
